@@ hdl/obm_pkg.sv @@
// ----------------------------------------------------------------------------
// obm_pkg: shared definitions of the bid side order book matcher
// Constants, codes, state encoding and control structures.
// ----------------------------------------------------------------------------
package obm_pkg;

  localparam int ORDER_SLOTS_DEF = 64;
  localparam int PRICE_TICKS_DEF = 1024;
  localparam int QTY_BITS_DEF    = 32;

  localparam int MAX_RESULTS = 64;
  localparam int RES_IDX_W   = 6;
  localparam int RES_CNT_W   = 7;

  localparam logic [1:0] OP_LIMIT_BUY  = 2'd0;
  localparam logic [1:0] OP_LIMIT_SELL = 2'd1;
  localparam logic [1:0] OP_MARKET_SELL = 2'd2;
  localparam logic [1:0] OP_QUERY      = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_QTY  = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_QRY,
    S_BUY1,
    S_BUY2,
    S_FILL0,
    S_FILL1,
    S_FILL2,
    S_SCAN,
    S_SCANCHK,
    S_TOP,
    S_TOP2,
    S_ONE,
    S_ERD,
    S_ELD,
    S_EWAIT
  } obm_state_t;

  typedef struct packed {
    logic alloc;
    logic release_slot;
    logic take_id;
  } pool_cmd_t;

endpackage

@@ hdl/obm_pool.sv @@
// ----------------------------------------------------------------------------
// obm_pool: order slot allocator and id counter
// Keeps the free slot mask, picks the lowest free slot and hands out ids.
// ----------------------------------------------------------------------------
module obm_pool #(
  parameter int ORDER_SLOTS = obm_pkg::ORDER_SLOTS_DEF,
  localparam int SW = $clog2(ORDER_SLOTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  obm_pkg::pool_cmd_t cmd,
  input  logic [SW-1:0]      rel_slot,
  output logic               any_free,
  output logic [SW-1:0]      free_slot,
  output logic [31:0]        next_id
);

  logic [ORDER_SLOTS-1:0] free_r, free_nxt;
  logic [31:0]            id_r, id_nxt;

  always_comb begin
    free_slot = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  assign any_free = |free_r;
  assign next_id  = id_r;

  always_comb begin
    free_nxt = free_r;
    if (cmd.alloc) begin
      free_nxt[free_slot] = 1'b0;
    end
    if (cmd.release_slot) begin
      free_nxt[rel_slot] = 1'b1;
    end
    id_nxt = id_r;
    if (cmd.take_id) begin
      id_nxt = (id_r == 32'hFFFF_FFFF) ? 32'd1 : id_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
      id_r   <= 32'd1;
    end else begin
      free_r <= free_nxt;
      id_r   <= id_nxt;
    end
  end

endmodule

@@ hdl/obm_rbuf.sv @@
// ----------------------------------------------------------------------------
// obm_rbuf: trade result buffer
// Holds the trades of one sell until the final book state is known.
// ----------------------------------------------------------------------------
module obm_rbuf #(
  parameter int QTY_BITS = obm_pkg::QTY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [obm_pkg::RES_IDX_W-1:0] wr_addr,
  input  logic [31:0]                  wr_maker,
  input  logic [9:0]                   wr_price,
  input  logic [QTY_BITS-1:0]          wr_qty,
  input  logic                         rd_en,
  input  logic [obm_pkg::RES_IDX_W-1:0] rd_addr,
  output logic [31:0]                  rd_maker,
  output logic [9:0]                   rd_price,
  output logic [QTY_BITS-1:0]          rd_qty
);

  localparam int EW = 32 + 10 + QTY_BITS;

  logic [EW-1:0] mem [obm_pkg::MAX_RESULTS];
  logic [EW-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_maker, wr_price, wr_qty};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_maker = rd_q[EW-1 -: 32];
  assign rd_price = rd_q[QTY_BITS +: 10];
  assign rd_qty   = rd_q[QTY_BITS-1:0];

endmodule

@@ hdl/bid_side_order_book_matcher.sv @@
// ----------------------------------------------------------------------------
// bid_side_order_book_matcher: bid side limit order book
// Price-time priority bid book with per-level FIFOs, fills of sells against
// the best bid, and a downward rescan when a level empties.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in_      input      in_valid / in_ready     operation, price, quantity, timestamp
// out_     output     out_valid / out_ready   status, ids, trade, top of book, depth
//
// After reset a clearing pass zeroes the level totals.
// A buy reads its level, links the new order and reads the top of book; a
// query reads its level first, and a rejected order goes straight to the top
// of book read. A sell repeats its fill steps, ends the fill loop, reads each
// level in turn in the downward best bid rescan, and then reads the top of
// book. Each trade result is read from the result buffer and held through any
// output stall. A new item is accepted only after the last result transfer.
// ----------------------------------------------------------------------------
module bid_side_order_book_matcher #(
  parameter int ORDER_SLOTS = obm_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_TICKS = obm_pkg::PRICE_TICKS_DEF,
  parameter int QTY_BITS    = obm_pkg::QTY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [9:0]  in_price,
  input  logic [31:0] in_quantity,
  input  logic [63:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_order_id,
  output logic [31:0] out_maker_id,
  output logic [9:0]  out_trade_price,
  output logic [31:0] out_trade_qty,
  output logic [63:0] out_trade_time,
  output logic        out_is_trade,
  output logic        out_last,
  output logic [9:0]  out_top_price,
  output logic [37:0] out_top_qty,
  output logic        out_bid_present,
  output logic [37:0] out_depth_qty
);

  localparam int SW  = $clog2(ORDER_SLOTS);
  localparam int PW  = $clog2(PRICE_TICKS);
  localparam int LTW = QTY_BITS + SW;
  localparam int RIW = obm_pkg::RES_IDX_W;
  localparam int RCW = obm_pkg::RES_CNT_W;

  // Level and slot memories.
  logic [LTW-1:0]      lt_mem [PRICE_TICKS];
  logic [SW-1:0]       lh_mem [PRICE_TICKS];
  logic [SW-1:0]       ltl_mem [PRICE_TICKS];
  logic [SW-1:0]       sn_mem [ORDER_SLOTS];
  logic [31:0]         sid_mem [ORDER_SLOTS];
  logic [QTY_BITS-1:0] srem_mem [ORDER_SLOTS];

  logic [LTW-1:0]      lt_q;
  logic [SW-1:0]       lh_q, ltl_q, sn_q;
  logic [31:0]         sid_q;
  logic [QTY_BITS-1:0] srem_q;

  logic                lt_we, lt_re, lh_we, lh_re, ltl_we, ltl_re;
  logic [PW-1:0]       lt_wa, lt_ra, lh_wa, lh_ra, ltl_wa, ltl_ra;
  logic [LTW-1:0]      lt_wd;
  logic [SW-1:0]       lh_wd, ltl_wd;
  logic                sn_we, sn_re, sid_we, sid_re, srem_we, srem_re;
  logic [SW-1:0]       sn_wa, sn_ra, sid_wa, sid_ra, srem_wa, srem_ra;
  logic [SW-1:0]       sn_wd;
  logic [31:0]         sid_wd;
  logic [QTY_BITS-1:0] srem_wd;

  always_ff @(posedge clk) begin
    if (lt_we) begin
      lt_mem[lt_wa] <= lt_wd;
    end
    if (lt_re) begin
      lt_q <= lt_mem[lt_ra];
    end
    if (lh_we) begin
      lh_mem[lh_wa] <= lh_wd;
    end
    if (lh_re) begin
      lh_q <= lh_mem[lh_ra];
    end
    if (ltl_we) begin
      ltl_mem[ltl_wa] <= ltl_wd;
    end
    if (ltl_re) begin
      ltl_q <= ltl_mem[ltl_ra];
    end
    if (sn_we) begin
      sn_mem[sn_wa] <= sn_wd;
    end
    if (sn_re) begin
      sn_q <= sn_mem[sn_ra];
    end
    if (sid_we) begin
      sid_mem[sid_wa] <= sid_wd;
    end
    if (sid_re) begin
      sid_q <= sid_mem[sid_ra];
    end
    if (srem_we) begin
      srem_mem[srem_wa] <= srem_wd;
    end
    if (srem_re) begin
      srem_q <= srem_mem[srem_ra];
    end
  end

  // Slot pool and result buffer.
  obm_pkg::pool_cmd_t pcmd;
  logic               any_free;
  logic [SW-1:0]      free_slot;
  logic [31:0]        next_id;
  logic [SW-1:0]      slot_r, slot_nxt;

  obm_pool #(.ORDER_SLOTS(ORDER_SLOTS)) u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pcmd),
    .rel_slot  (slot_r),
    .any_free  (any_free),
    .free_slot (free_slot),
    .next_id   (next_id)
  );

  logic                rb_we, rb_re;
  logic [RIW-1:0]      rb_wa, rb_ra;
  logic [31:0]         rb_wmaker, rb_rmaker;
  logic [9:0]          rb_wprice, rb_rprice;
  logic [QTY_BITS-1:0] rb_wqty, rb_rqty;

  obm_rbuf #(.QTY_BITS(QTY_BITS)) u_rbuf (
    .clk      (clk),
    .wr_en    (rb_we),
    .wr_addr  (rb_wa),
    .wr_maker (rb_wmaker),
    .wr_price (rb_wprice),
    .wr_qty   (rb_wqty),
    .rd_en    (rb_re),
    .rd_addr  (rb_ra),
    .rd_maker (rb_rmaker),
    .rd_price (rb_rprice),
    .rd_qty   (rb_rqty)
  );

  // Control and working registers.
  obm_pkg::obm_state_t state_r, state_nxt;
  logic [PW-1:0]       clr_r, clr_nxt;
  logic [PW-1:0]       best_r, best_nxt;
  logic                nonempty_r, nonempty_nxt;
  logic [RCW-1:0]      n_r, n_nxt;
  logic [RIW-1:0]      e_r, e_nxt;
  logic [PW-1:0]       scan_r, scan_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [PW-1:0]       p_r, p_nxt;
  logic                market_r, market_nxt;
  logic                qok_r, qok_nxt;
  logic [QTY_BITS-1:0] rem_r, rem_nxt;
  logic [63:0]         ts_r, ts_nxt;
  logic [31:0]         oid_r, oid_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [LTW-1:0]      depth_r, depth_nxt;
  logic [LTW-1:0]      topq_r, topq_nxt;

  logic [1:0]          o_status_r, o_status_nxt;
  logic [31:0]         o_oid_r, o_oid_nxt, o_maker_r, o_maker_nxt;
  logic [9:0]          o_tprice_r, o_tprice_nxt, o_top_r, o_top_nxt;
  logic [QTY_BITS-1:0] o_tqty_r, o_tqty_nxt;
  logic [63:0]         o_time_r, o_time_nxt;
  logic                o_trade_r, o_trade_nxt, o_last_r, o_last_nxt;
  logic                o_present_r, o_present_nxt;
  logic [LTW-1:0]      o_topq_r, o_topq_nxt, o_depth_r, o_depth_nxt;

  // Input decode.
  logic [16:0]         in_p_ext, in_p_cl;
  logic [47:0]         in_q_ext;
  logic [QTY_BITS-1:0] in_qty;

  assign in_p_ext = 17'(in_price);
  assign in_p_cl  = (in_p_ext >= 17'(PRICE_TICKS)) ? 17'(PRICE_TICKS - 1) : in_p_ext;
  assign in_q_ext = 48'(in_quantity);
  assign in_qty   = in_q_ext[QTY_BITS-1:0];

  // Fill arithmetic.
  logic [QTY_BITS-1:0] fill, srem_left;
  logic [LTW-1:0]      lt_left;

  assign fill      = (rem_r < srem_q) ? rem_r : srem_q;
  assign srem_left = srem_q - fill;
  assign lt_left   = lt_q - LTW'(fill);

  assign in_ready = (state_r == obm_pkg::S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    best_nxt      = best_r;
    nonempty_nxt  = nonempty_r;
    n_nxt         = n_r;
    e_nxt         = e_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r;
    p_nxt         = p_r;
    market_nxt    = market_r;
    qok_nxt       = qok_r;
    rem_nxt       = rem_r;
    ts_nxt        = ts_r;
    slot_nxt      = slot_r;
    oid_nxt       = oid_r;
    status_nxt    = status_r;
    depth_nxt     = depth_r;
    topq_nxt      = topq_r;
    o_status_nxt  = o_status_r;
    o_oid_nxt     = o_oid_r;
    o_maker_nxt   = o_maker_r;
    o_tprice_nxt  = o_tprice_r;
    o_tqty_nxt    = o_tqty_r;
    o_time_nxt    = o_time_r;
    o_trade_nxt   = o_trade_r;
    o_last_nxt    = o_last_r;
    o_top_nxt     = o_top_r;
    o_topq_nxt    = o_topq_r;
    o_present_nxt = o_present_r;
    o_depth_nxt   = o_depth_r;

    lt_we = 1'b0;  lt_re = 1'b0;  lt_wa = best_r;  lt_ra = best_r;  lt_wd = '0;
    lh_we = 1'b0;  lh_re = 1'b0;  lh_wa = best_r;  lh_ra = best_r;  lh_wd = '0;
    ltl_we = 1'b0; ltl_re = 1'b0; ltl_wa = p_r;    ltl_ra = p_r;    ltl_wd = '0;
    sn_we = 1'b0;  sn_re = 1'b0;  sn_wa = slot_r;  sn_ra = slot_r;  sn_wd = '0;
    sid_we = 1'b0; sid_re = 1'b0; sid_wa = slot_r; sid_ra = slot_r; sid_wd = oid_r;
    srem_we = 1'b0; srem_re = 1'b0; srem_wa = slot_r; srem_ra = slot_r;
    srem_wd = rem_r;
    pcmd = '0;
    rb_we = 1'b0; rb_wa = n_r[RIW-1:0]; rb_wmaker = sid_q;
    rb_wprice = 10'(best_r); rb_wqty = fill;
    rb_re = 1'b0; rb_ra = e_r;

    case (state_r)
      obm_pkg::S_CLEAR: begin
        lt_we = 1'b1;
        lt_wa = clr_r;
        clr_nxt = clr_r + PW'(1);
        if (clr_r == PW'(PRICE_TICKS - 1)) begin
          state_nxt = obm_pkg::S_IDLE;
        end
      end
      obm_pkg::S_IDLE: begin
        out_valid_nxt = 1'b0;
        if (in_valid) begin
          p_nxt      = in_p_cl[PW-1:0];
          market_nxt = (in_operation == obm_pkg::OP_MARKET_SELL);
          qok_nxt    = (in_p_ext < 17'(PRICE_TICKS));
          rem_nxt    = in_qty;
          ts_nxt     = in_timestamp;
          n_nxt      = '0;
          depth_nxt  = '0;
          status_nxt = obm_pkg::ST_OK;
          oid_nxt    = '0;
          if (in_operation == obm_pkg::OP_QUERY) begin
            lt_re = 1'b1;
            lt_ra = in_p_cl[PW-1:0];
            state_nxt = obm_pkg::S_QRY;
          end else if (in_qty == '0) begin
            status_nxt = obm_pkg::ST_BAD_QTY;
            state_nxt  = obm_pkg::S_TOP;
          end else if (in_operation == obm_pkg::OP_LIMIT_BUY) begin
            if (!any_free) begin
              status_nxt = obm_pkg::ST_POOL_FULL;
              state_nxt  = obm_pkg::S_TOP;
            end else begin
              pcmd.alloc   = 1'b1;
              pcmd.take_id = 1'b1;
              slot_nxt     = free_slot;
              oid_nxt      = next_id;
              lt_re  = 1'b1;
              lt_ra  = in_p_cl[PW-1:0];
              ltl_re = 1'b1;
              ltl_ra = in_p_cl[PW-1:0];
              state_nxt = obm_pkg::S_BUY1;
            end
          end else begin
            pcmd.take_id = 1'b1;
            oid_nxt      = next_id;
            state_nxt    = obm_pkg::S_FILL0;
          end
        end
      end
      obm_pkg::S_QRY: begin
        depth_nxt = qok_r ? lt_q : '0;
        state_nxt = obm_pkg::S_TOP;
      end
      obm_pkg::S_BUY1: begin
        if (lt_q == '0) begin
          lh_we = 1'b1;
          lh_wa = p_r;
          lh_wd = slot_r;
        end else begin
          sn_we = 1'b1;
          sn_wa = ltl_q;
          sn_wd = slot_r;
        end
        ltl_we  = 1'b1;
        ltl_wd  = slot_r;
        lt_we   = 1'b1;
        lt_wa   = p_r;
        lt_wd   = lt_q + LTW'(rem_r);
        sid_we  = 1'b1;
        srem_we = 1'b1;
        if (!nonempty_r || p_r > best_r) begin
          best_nxt     = p_r;
          nonempty_nxt = 1'b1;
        end
        state_nxt = obm_pkg::S_BUY2;
      end
      obm_pkg::S_BUY2: begin
        sn_we = 1'b1;
        state_nxt = obm_pkg::S_TOP;
      end
      obm_pkg::S_FILL0: begin
        if (rem_r != '0 && nonempty_r && n_r < RCW'(obm_pkg::MAX_RESULTS) &&
            (market_r || best_r >= p_r)) begin
          lh_re = 1'b1;
          lt_re = 1'b1;
          state_nxt = obm_pkg::S_FILL1;
        end else begin
          state_nxt = obm_pkg::S_TOP;
        end
      end
      obm_pkg::S_FILL1: begin
        slot_nxt = lh_q;
        sn_re   = 1'b1;
        sn_ra   = lh_q;
        sid_re  = 1'b1;
        sid_ra  = lh_q;
        srem_re = 1'b1;
        srem_ra = lh_q;
        state_nxt = obm_pkg::S_FILL2;
      end
      obm_pkg::S_FILL2: begin
        rb_we   = 1'b1;
        srem_we = 1'b1;
        srem_wd = srem_left;
        lt_we   = 1'b1;
        lt_wd   = lt_left;
        rem_nxt = rem_r - fill;
        n_nxt   = n_r + RCW'(1);
        if (srem_left == '0) begin
          pcmd.release_slot = 1'b1;
          lh_we = 1'b1;
          lh_wd = sn_q;
        end
        if (lt_left == '0) begin
          scan_nxt  = best_r;
          state_nxt = obm_pkg::S_SCAN;
        end else begin
          state_nxt = obm_pkg::S_FILL0;
        end
      end
      obm_pkg::S_SCAN: begin
        if (scan_r == '0) begin
          best_nxt     = '0;
          nonempty_nxt = 1'b0;
          state_nxt    = obm_pkg::S_FILL0;
        end else begin
          lt_re    = 1'b1;
          lt_ra    = scan_r - PW'(1);
          scan_nxt = scan_r - PW'(1);
          state_nxt = obm_pkg::S_SCANCHK;
        end
      end
      obm_pkg::S_SCANCHK: begin
        if (lt_q != '0) begin
          best_nxt  = scan_r;
          state_nxt = obm_pkg::S_FILL0;
        end else begin
          state_nxt = obm_pkg::S_SCAN;
        end
      end
      obm_pkg::S_TOP: begin
        lt_re = 1'b1;
        state_nxt = obm_pkg::S_TOP2;
      end
      obm_pkg::S_TOP2: begin
        topq_nxt = nonempty_r ? lt_q : '0;
        e_nxt    = '0;
        state_nxt = (n_r == '0) ? obm_pkg::S_ONE : obm_pkg::S_ERD;
      end
      obm_pkg::S_ONE: begin
        o_status_nxt  = status_r;
        o_oid_nxt     = oid_r;
        o_maker_nxt   = '0;
        o_tprice_nxt  = '0;
        o_tqty_nxt    = '0;
        o_time_nxt    = '0;
        o_trade_nxt   = 1'b0;
        o_last_nxt    = 1'b1;
        o_top_nxt     = nonempty_r ? 10'(best_r) : 10'd0;
        o_topq_nxt    = topq_r;
        o_present_nxt = nonempty_r;
        o_depth_nxt   = depth_r;
        out_valid_nxt = 1'b1;
        state_nxt     = obm_pkg::S_EWAIT;
      end
      obm_pkg::S_ERD: begin
        rb_re = 1'b1;
        state_nxt = obm_pkg::S_ELD;
      end
      obm_pkg::S_ELD: begin
        o_status_nxt  = status_r;
        o_oid_nxt     = oid_r;
        o_maker_nxt   = rb_rmaker;
        o_tprice_nxt  = rb_rprice;
        o_tqty_nxt    = rb_rqty;
        o_time_nxt    = ts_r;
        o_trade_nxt   = 1'b1;
        o_last_nxt    = (RCW'(e_r) == n_r - RCW'(1));
        o_top_nxt     = nonempty_r ? 10'(best_r) : 10'd0;
        o_topq_nxt    = topq_r;
        o_present_nxt = nonempty_r;
        o_depth_nxt   = depth_r;
        out_valid_nxt = 1'b1;
        state_nxt     = obm_pkg::S_EWAIT;
      end
      obm_pkg::S_EWAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (o_last_r) begin
            state_nxt = obm_pkg::S_IDLE;
          end else begin
            e_nxt     = e_r + RIW'(1);
            state_nxt = obm_pkg::S_ERD;
          end
        end
      end
      default: begin
        state_nxt = obm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= obm_pkg::S_CLEAR;
      clr_r       <= '0;
      best_r      <= '0;
      nonempty_r  <= 1'b0;
      n_r         <= '0;
      e_r         <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      best_r      <= best_nxt;
      nonempty_r  <= nonempty_nxt;
      n_r         <= n_nxt;
      e_r         <= e_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    market_r    <= market_nxt;
    qok_r       <= qok_nxt;
    rem_r       <= rem_nxt;
    ts_r        <= ts_nxt;
    slot_r      <= slot_nxt;
    oid_r       <= oid_nxt;
    status_r    <= status_nxt;
    depth_r     <= depth_nxt;
    topq_r      <= topq_nxt;
    o_status_r  <= o_status_nxt;
    o_oid_r     <= o_oid_nxt;
    o_maker_r   <= o_maker_nxt;
    o_tprice_r  <= o_tprice_nxt;
    o_tqty_r    <= o_tqty_nxt;
    o_time_r    <= o_time_nxt;
    o_trade_r   <= o_trade_nxt;
    o_last_r    <= o_last_nxt;
    o_top_r     <= o_top_nxt;
    o_topq_r    <= o_topq_nxt;
    o_present_r <= o_present_nxt;
    o_depth_r   <= o_depth_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_order_id    = o_oid_r;
  assign out_maker_id    = o_maker_r;
  assign out_trade_price = o_tprice_r;
  assign out_trade_qty   = 32'(o_tqty_r);
  assign out_trade_time  = o_time_r;
  assign out_is_trade    = o_trade_r;
  assign out_last        = o_last_r;
  assign out_top_price   = o_top_r;
  assign out_top_qty     = 38'(o_topq_r);
  assign out_bid_present = o_present_r;
  assign out_depth_qty   = 38'(o_depth_r);

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bid side order book matcher
// Directed table rows followed by random order flow (mostly resting buys and
// crossing sells at nearby prices), checked against an in-bench book model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS = 64;
  localparam int TICKS = 1024;
  localparam longint CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  price;
    logic [31:0] qty;
    logic [63:0] ts;
  } order_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] oid;
    logic [31:0] maker;
    logic [9:0]  trade_price;
    logic [31:0] trade_qty;
    logic [63:0] trade_time;
    logic        is_trade;
    logic        last;
    logic [9:0]  top_price;
    logic [37:0] top_qty;
    logic        bid_present;
    logic [37:0] depth_qty;
  } report_t;

  typedef struct {
    order_t  ord;
    logic    typed;
    report_t rep;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [9:0] in_price = '0;
  logic [31:0] in_quantity = '0;
  logic [63:0] in_timestamp = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [31:0] out_order_id, out_maker_id, out_trade_qty;
  logic [9:0] out_trade_price, out_top_price;
  logic [63:0] out_trade_time;
  logic out_is_trade, out_last, out_bid_present;
  logic [37:0] out_top_qty, out_depth_qty;

  bid_side_order_book_matcher DUT (.*);

  always #5 clk = ~clk;

  logic [63:0] bk_total [TICKS];
  logic [5:0]  bk_head [TICKS];
  logic [5:0]  bk_tail [TICKS];
  logic [5:0]  sl_next [SLOTS];
  logic [31:0] sl_id [SLOTS];
  logic [31:0] sl_rem [SLOTS];
  logic [63:0] bk_free;
  logic [31:0] bk_next_id;
  logic [9:0]  bk_best;
  logic        bk_any;

  report_t expected_reports[$];
  int errors = 0;
  int trades_seen = 0;
  int reports_seen = 0;
  int phase = 0;
  int hold_off = 0;
  logic stall_done = 1'b0;
  longint cycles = 0;

  function automatic logic [31:0] grab_id();
    logic [31:0] id;
    id = bk_next_id;
    bk_next_id = (bk_next_id == 32'hFFFF_FFFF) ? 32'd1 : bk_next_id + 32'd1;
    return id;
  endfunction

  function automatic void book_step(order_t o);
    report_t r;
    report_t batch[$];
    logic [5:0] s;
    logic [9:0] p;
    logic [31:0] id, rem, fill;
    logic [63:0] depth;
    logic [9:0] bp;
    depth = 0;
    r = '0;
    p = o.price;
    if (o.op == obm_pkg::OP_QUERY) begin
      depth = bk_total[o.price];
      batch = {batch, r};
    end else if (o.qty == 0) begin
      r.status = obm_pkg::ST_BAD_QTY;
      batch = {batch, r};
    end else if (o.op == obm_pkg::OP_LIMIT_BUY) begin
      if (bk_free == 0) begin
        r.status = obm_pkg::ST_POOL_FULL;
        batch = {batch, r};
      end else begin
        s = '0;
        while (!bk_free[s]) s++;
        bk_free[s] = 1'b0;
        id = grab_id();
        sl_id[s] = id;
        sl_rem[s] = o.qty;
        sl_next[s] = '0;
        if (bk_total[p] == 0) bk_head[p] = s;
        else sl_next[bk_tail[p]] = s;
        bk_tail[p] = s;
        bk_total[p] += o.qty;
        if (!bk_any || p > bk_best) begin
          bk_best = p;
          bk_any = 1'b1;
        end
        r.oid = id;
        batch = {batch, r};
      end
    end else begin
      id = grab_id();
      rem = o.qty;
      while (rem > 0 && bk_any && batch.size() < 64 &&
             (o.op == obm_pkg::OP_MARKET_SELL || bk_best >= p)) begin
        bp = bk_best;
        s = bk_head[bp];
        fill = (rem < sl_rem[s]) ? rem : sl_rem[s];
        r = '0;
        r.oid = id;
        r.maker = sl_id[s];
        r.trade_price = bp;
        r.trade_qty = fill;
        r.trade_time = o.ts;
        r.is_trade = 1'b1;
        batch = {batch, r};
        sl_rem[s] -= fill;
        bk_total[bp] -= fill;
        rem -= fill;
        if (sl_rem[s] == 0) begin
          bk_free[s] = 1'b1;
          bk_head[bp] = sl_next[s];
        end
        if (bk_total[bp] == 0) begin
          while (bk_best > 0 && bk_total[bk_best] == 0) bk_best--;
          if (bk_total[bk_best] == 0) begin
            bk_best = 0;
            bk_any = 1'b0;
          end
        end
      end
      if (batch.size() == 0) begin
        r = '0;
        r.oid = id;
        batch = {batch, r};
      end
    end
    foreach (batch[k]) begin
      batch[k].last = (k == batch.size() - 1);
      batch[k].top_price = bk_any ? bk_best : 10'd0;
      batch[k].top_qty = bk_any ? bk_total[bk_best][37:0] : 38'd0;
      batch[k].bid_present = bk_any;
      batch[k].depth_qty = depth[37:0];
      expected_reports = {expected_reports, batch[k]};
    end
  endfunction

  report_t seen;
  assign seen = '{out_status, out_order_id, out_maker_id, out_trade_price, out_trade_qty,
                  out_trade_time, out_is_trade, out_last, out_top_price, out_top_qty,
                  out_bid_present, out_depth_qty};

  always @(posedge clk) begin
    report_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      reports_seen <= reports_seen + 1;
      if (out_is_trade) trades_seen <= trades_seen + 1;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result %h", $time, seen);
        errors <= errors + 1;
      end else begin
        want = expected_reports.pop_front();
        if (want !== seen) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, seen);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (phase == 1 && !stall_done) begin
      stall_done <= 1'b1;
      hold_off <= 400;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      case (phase)
        1: out_ready <= ($urandom_range(99) >= 75);
        2: out_ready <= ($urandom_range(99) >= 13);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  task automatic send(order_t o);
    int gap;
    gap = 0;
    if (phase == 3) gap = ($urandom_range(99) < 75) ? $urandom_range(6, 1) : 0;
    if (phase == 2) gap = ($urandom_range(99) < 13) ? $urandom_range(3, 1) : 0;
    repeat (gap + 1) @(negedge clk);
    in_valid <= 1'b1;
    {in_operation, in_price, in_quantity, in_timestamp} <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book_step(o);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic order_t random_order(int base);
    order_t o;
    int pick;
    o.ts = {$urandom, $urandom};
    pick = $urandom_range(99);
    o.price = 10'(base + $urandom_range(15));
    o.qty = $urandom_range(1, 50);
    if (pick < 50) o.op = obm_pkg::OP_LIMIT_BUY;
    else if (pick < 75) o.op = obm_pkg::OP_LIMIT_SELL;
    else if (pick < 85) o.op = obm_pkg::OP_MARKET_SELL;
    else o.op = obm_pkg::OP_QUERY;
    if (o.op != obm_pkg::OP_LIMIT_BUY && o.op != obm_pkg::OP_QUERY) begin
      o.qty = $urandom_range(1, 200);
    end
    if ($urandom_range(99) < 5) o.qty = 0;
    if ($urandom_range(99) < 5) o.qty = $urandom;
    if ($urandom_range(99) < 3) o.price = 10'($urandom);
    return o;
  endfunction

  row_t rows[$];

  task automatic add_row(logic [1:0] op, logic [9:0] pr, logic [31:0] q, logic [63:0] t);
    row_t r;
    r.ord = '{op, pr, q, t};
    r.typed = 1'b0;
    r.rep = '0;
    rows = {rows, r};
  endtask

  initial begin
    order_t o;
    int base;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    bk_free = '1;
    bk_next_id = 1;
    bk_best = 0;
    bk_any = 0;
    for (int i = 0; i < TICKS; i++) bk_total[i] = 0;

    add_row(obm_pkg::OP_QUERY, 10'd1023, 32'hFFFF_FFFF, '1);
    rows[0].typed = 1'b1;
    rows[0].rep.last = 1'b1;
    add_row(obm_pkg::OP_LIMIT_BUY, 10'd5, 32'd0, '0);
    rows[1].typed = 1'b1;
    rows[1].rep.status = obm_pkg::ST_BAD_QTY;
    rows[1].rep.last = 1'b1;
    add_row(obm_pkg::OP_LIMIT_SELL, 10'd0, 32'd10, 64'h1);
    add_row(obm_pkg::OP_LIMIT_BUY, 10'd0, 32'd1, '0);
    add_row(obm_pkg::OP_LIMIT_BUY, 10'd1023, 32'hFFFF_FFFF, '1);
    add_row(obm_pkg::OP_LIMIT_BUY, 10'd1023, 32'hFFFF_FFFF, '0);
    add_row(obm_pkg::OP_LIMIT_BUY, 10'd500, 32'd7, '0);
    add_row(obm_pkg::OP_LIMIT_BUY, 10'd500, 32'd3, '0);
    add_row(obm_pkg::OP_QUERY, 10'd500, 32'd0, '0);
    add_row(obm_pkg::OP_QUERY, 10'd1023, 32'd0, '0);
    add_row(obm_pkg::OP_LIMIT_SELL, 10'd1023, 32'hFFFF_FFFF, 64'hAAAA_5555_0F0F_F0F0);
    add_row(obm_pkg::OP_LIMIT_SELL, 10'd600, 32'd5, 64'h5555_AAAA_F0F0_0F0F);
    add_row(obm_pkg::OP_MARKET_SELL, 10'd1023, 32'd0, '0);
    add_row(obm_pkg::OP_MARKET_SELL, 10'd1023, 32'd6, '1);
    add_row(obm_pkg::OP_MARKET_SELL, 10'd0, 32'hFFFF_FFFF, 64'h3);
    for (int i = 0; i < 65; i++) add_row(obm_pkg::OP_LIMIT_BUY, i[9:0], 32'd1, '0);
    add_row(obm_pkg::OP_MARKET_SELL, 10'd0, 32'd100, 64'h77);
    add_row(obm_pkg::OP_MARKET_SELL, 10'd0, 32'd100, 64'h78);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        send(rows[i].ord);
        void'(expected_reports.pop_back());
        expected_reports = {expected_reports, rows[i].rep};
      end else begin
        send(rows[i].ord);
      end
    end

    for (phase = 0; phase < 4; phase++) begin
      base = $urandom_range(1000);
      for (int n = 0; n < 30; n++) begin
        o = random_order(base);
        send(o);
      end
      while (expected_reports.size() != 0) @(posedge clk);
    end
    phase = 0;
    repeat (200) @(posedge clk);
    $display("Covered %0d results with %0d trades over directed and random order flow.",
             reports_seen, trades_seen);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
